FILE: src/bidirectional_flow_tracker_macros.svh
// Assertion helpers for the stream tracker; they expect clk and arst_n in scope.
`ifndef BIDIRECTIONAL_FLOW_TRACKER_MACROS_SVH
`define BIDIRECTIONAL_FLOW_TRACKER_MACROS_SVH

// same-cycle implication
`define BFT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bft_pkg.sv
package bft_pkg;

	localparam int OUT_IDX_W = 10;

	typedef struct packed {
		logic        is_ipv6;
		logic [63:0] src_addr_hi;
		logic [63:0] src_addr_lo;
		logic [15:0] src_l4;
		logic [63:0] dst_addr_hi;
		logic [63:0] dst_addr_lo;
		logic [15:0] dst_l4;
		logic [31:0] flow_id;
	} key_t;

	localparam int KEY_W = $bits(key_t);

	// complete flag and reverse id
	typedef struct packed {
		logic        complete;
		logic [31:0] rev_id;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	typedef enum logic [2:0] {
		OUT_EST       = 3'd0,
		OUT_PEND_FWD  = 3'd1,
		OUT_COMPLETED = 3'd2,
		OUT_CREATED   = 3'd3,
		OUT_FULL      = 3'd4
	} outcome_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] stream_index;
		logic                 direction;
		outcome_t             outcome;
		logic                 is_complete;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} eng_state_t;

endpackage

FILE: src/bft_if.sv
interface bft_in_if;
	logic        valid;
	logic        ready;
	logic        is_ipv6;
	logic [63:0] src_addr_hi;
	logic [63:0] src_addr_lo;
	logic [15:0] src_l4;
	logic [63:0] dst_addr_hi;
	logic [63:0] dst_addr_lo;
	logic [15:0] dst_l4;
	logic [31:0] flow_id;

	modport source (output valid, is_ipv6, src_addr_hi, src_addr_lo, src_l4,
		dst_addr_hi, dst_addr_lo, dst_l4, flow_id, input ready);
	modport sink (input valid, is_ipv6, src_addr_hi, src_addr_lo, src_l4,
		dst_addr_hi, dst_addr_lo, dst_l4, flow_id, output ready);
endinterface

interface bft_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  stream_index;
	logic        direction;
	logic [2:0]  outcome;
	logic        is_complete;

	modport source (output valid, stream_index, direction, outcome, is_complete,
		input ready);
	modport sink (input valid, stream_index, direction, outcome, is_complete,
		output ready);
endinterface

FILE: src/bidirectional_flow_tracker.sv
// Per request: pop, scan the stored streams, drain, decide; an empty table skips to decide.
// The engine reads one stream per cycle from the entry RAM read port and compares it.
// The engine takes one request at a time; a two-entry queue keeps accepting input meanwhile.
// Reset (arst_n low, asynchronous) empties the queue and sets the stream count to zero;
// the table RAMs are not cleared, entries beyond the count are never read.
module bidirectional_flow_tracker #(
	parameter int MAX_STREAMS = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	bft_in_if.sink   pkt,
	bft_out_if.source res
);
	import bft_pkg::*;

`include "bidirectional_flow_tracker_macros.svh"

	logic q_valid;
	key_t q_key;
	logic q_pop;
	res_t out_res;

	bft_front u_front (
		.clk(clk), .arst_n(arst_n), .pkt(pkt),
		.q_valid(q_valid), .q_key(q_key), .q_pop(q_pop)
	);

	bft_engine #(.MAX_STREAMS(MAX_STREAMS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_key(q_key), .q_pop(q_pop),
		.out_ready(res.ready), .out_valid(res.valid), .out_res(out_res)
	);

	assign res.stream_index = out_res.stream_index;
	assign res.direction    = out_res.direction;
	assign res.outcome      = out_res.outcome;
	assign res.is_complete  = out_res.is_complete;

	`BFT_ASSERT_NOW(a_pop_has_data, q_pop, q_valid, "queue popped while empty")
	`BFT_ASSERT_NOW(a_full_fields, res.valid && res.outcome == OUT_FULL,
		res.stream_index == '0 && !res.direction && !res.is_complete, "bad full result")
	`BFT_ASSERT_NOW(a_est_complete, res.valid && res.outcome == OUT_EST,
		res.is_complete, "established hit on incomplete stream")
	`BFT_ASSERT_NEXT(a_pop_no_repop, q_pop, !q_pop, "two requests started back to back")

endmodule

FILE: src/bft_ram.sv
module bft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/bft_front.sv
module bft_front (
	input  logic          clk,
	input  logic          arst_n,
	bft_in_if.sink        pkt,
	output logic          q_valid,
	output bft_pkg::key_t q_key,
	input  logic          q_pop
);
	import bft_pkg::*;

	key_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	key_t       key_in;
	logic       push;

	// IPv4 keeps only the low 32 address bits
	always_comb begin
		key_in.is_ipv6     = pkt.is_ipv6;
		key_in.src_addr_hi = pkt.is_ipv6 ? pkt.src_addr_hi : 64'd0;
		key_in.src_addr_lo = pkt.is_ipv6 ? pkt.src_addr_lo : {32'd0, pkt.src_addr_lo[31:0]};
		key_in.src_l4      = pkt.src_l4;
		key_in.dst_addr_hi = pkt.is_ipv6 ? pkt.dst_addr_hi : 64'd0;
		key_in.dst_addr_lo = pkt.is_ipv6 ? pkt.dst_addr_lo : {32'd0, pkt.dst_addr_lo[31:0]};
		key_in.dst_l4      = pkt.dst_l4;
		key_in.flow_id     = pkt.flow_id;
	end

	assign pkt.ready = (cnt_q != 2'd2);
	assign push      = pkt.valid && pkt.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_key     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= key_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

FILE: src/bft_engine.sv
module bft_engine #(
	parameter int MAX_STREAMS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  bft_pkg::key_t q_key,
	output logic          q_pop,
	input  logic          out_ready,
	output logic          out_valid,
	output bft_pkg::res_t out_res
);
	import bft_pkg::*;

	localparam int SW = $clog2(MAX_STREAMS);
	localparam int CW = SW + 1;

	eng_state_t state_q, state_d;
	key_t       key_q;
	logic [SW-1:0] cnt_q;
	logic [CW-1:0] used_q;
	logic          v_s1;
	logic [SW-1:0] idx_s1;

	logic          est_hit_q, est_dir_q, pf_hit_q, pr_hit_q;
	logic [SW-1:0] est_idx_q, pf_idx_q, pr_idx_q;

	logic out_valid_q;
	res_t out_q;

	logic [KEY_W-1:0]  ent_rdata;
	logic [META_W-1:0] meta_rdata;
	key_t  ent;
	meta_t meta;
	logic  re, last_issue, fire, full;
	logic  ent_we, meta_we;
	logic [SW-1:0] meta_waddr;
	meta_t meta_wdata;
	res_t  res;
	logic  fam_ok, fwd_t, rev_t, est_f, est_r;

	bft_ram #(.WIDTH(KEY_W), .DEPTH(MAX_STREAMS)) u_ent_ram (
		.clk(clk), .we(ent_we), .waddr(used_q[SW-1:0]), .wdata(key_q),
		.re(re), .raddr(cnt_q), .rdata(ent_rdata)
	);

	bft_ram #(.WIDTH(META_W), .DEPTH(MAX_STREAMS)) u_meta_ram (
		.clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
		.re(re), .raddr(cnt_q), .rdata(meta_rdata)
	);

	assign ent  = key_t'(ent_rdata);
	assign meta = meta_t'(meta_rdata);

	// per-slot compare on the registered RAM output
	always_comb begin
		fam_ok = (ent.is_ipv6 == key_q.is_ipv6);
		fwd_t  = ent.src_addr_hi == key_q.src_addr_hi && ent.src_addr_lo == key_q.src_addr_lo
			&& ent.src_l4 == key_q.src_l4 && ent.dst_addr_hi == key_q.dst_addr_hi
			&& ent.dst_addr_lo == key_q.dst_addr_lo && ent.dst_l4 == key_q.dst_l4;
		rev_t  = ent.dst_addr_hi == key_q.src_addr_hi && ent.dst_addr_lo == key_q.src_addr_lo
			&& ent.dst_l4 == key_q.src_l4 && ent.src_addr_hi == key_q.dst_addr_hi
			&& ent.src_addr_lo == key_q.dst_addr_lo && ent.src_l4 == key_q.dst_l4;
		est_f  = meta.complete && fwd_t && ent.flow_id == key_q.flow_id;
		est_r  = meta.complete && rev_t && meta.rev_id == key_q.flow_id;
	end

	assign last_issue = (CW'(cnt_q) + CW'(1)) == used_q;
	assign full       = used_q >= CW'(MAX_STREAMS);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		re      = 1'b0;
		fire    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = (used_q == '0) ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				re = 1'b1;
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!out_valid_q || out_ready) begin
					fire    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// rule priority: established, pending forward, pending reverse, create, else full
	always_comb begin
		res        = '{stream_index: '0, direction: 1'b0, outcome: OUT_FULL, is_complete: 1'b0};
		ent_we     = 1'b0;
		meta_we    = 1'b0;
		meta_waddr = used_q[SW-1:0];
		meta_wdata = '{complete: 1'b0, rev_id: 32'd0};
		if (est_hit_q) begin
			res = '{stream_index: OUT_IDX_W'(est_idx_q), direction: est_dir_q,
				outcome: OUT_EST, is_complete: 1'b1};
		end else if (pf_hit_q) begin
			res = '{stream_index: OUT_IDX_W'(pf_idx_q), direction: 1'b0,
				outcome: OUT_PEND_FWD, is_complete: 1'b0};
		end else if (pr_hit_q) begin
			res = '{stream_index: OUT_IDX_W'(pr_idx_q), direction: 1'b1,
				outcome: OUT_COMPLETED, is_complete: 1'b1};
			meta_we    = fire;
			meta_waddr = pr_idx_q;
			meta_wdata = '{complete: 1'b1, rev_id: key_q.flow_id};
		end else if (!full) begin
			res = '{stream_index: OUT_IDX_W'(used_q), direction: 1'b0,
				outcome: OUT_CREATED, is_complete: 1'b0};
			ent_we  = fire;
			meta_we = fire;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			used_q      <= '0;
			v_s1        <= 1'b0;
			est_hit_q   <= 1'b0;
			pf_hit_q    <= 1'b0;
			pr_hit_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= re;
			if (q_pop) begin
				cnt_q     <= '0;
				est_hit_q <= 1'b0;
				pf_hit_q  <= 1'b0;
				pr_hit_q  <= 1'b0;
			end else begin
				if (re) begin
					cnt_q <= cnt_q + SW'(1);
				end
				if (v_s1 && fam_ok) begin
					if (!est_hit_q && (est_f || est_r)) begin
						est_hit_q <= 1'b1;
					end
					if (!pf_hit_q && !meta.complete && fwd_t) begin
						pf_hit_q <= 1'b1;
					end
					if (!pr_hit_q && !meta.complete && rev_t) begin
						pr_hit_q <= 1'b1;
					end
				end
			end
			if (ent_we) begin
				used_q <= used_q + CW'(1);
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			key_q <= q_key;
		end
		idx_s1 <= cnt_q;
		if (v_s1 && fam_ok) begin
			if (!est_hit_q && (est_f || est_r)) begin
				est_idx_q <= idx_s1;
				est_dir_q <= !est_f;
			end
			if (!pf_hit_q && !meta.complete && fwd_t) begin
				pf_idx_q <= idx_s1;
			end
			if (!pr_hit_q && !meta.complete && rev_t) begin
				pr_idx_q <= idx_s1;
			end
		end
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

FILE: tb/bft_flow_checker.sv
module bft_flow_checker (
	input  logic clk,
	input  logic arst_n,
	bft_in_if    pkt,
	bft_out_if   res,
	output int   errors,
	output int   outstanding,
	output int   n_checked,
	output int   n_completed,
	output int   n_established,
	output int   n_full
);
	import bft_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOTS = 1024;

	// per-slot stream record; flow_id of the end key holds the forward id
	key_t        strm_key [NSLOTS];
	logic [31:0] strm_rev_id [NSLOTS];
	logic        strm_valid [NSLOTS];
	logic        strm_done [NSLOTS];
	int          strm_count;
	res_t        lookups_due [$];

	function automatic key_t clean_key(key_t k);
		if (!k.is_ipv6) begin
			k.src_addr_hi = '0;
			k.dst_addr_hi = '0;
			k.src_addr_lo[63:32] = '0;
			k.dst_addr_lo[63:32] = '0;
		end
		return k;
	endfunction

	function automatic bit ends_fwd(int s, key_t k);
		return strm_key[s].src_addr_hi == k.src_addr_hi && strm_key[s].src_addr_lo == k.src_addr_lo
			&& strm_key[s].src_l4 == k.src_l4 && strm_key[s].dst_addr_hi == k.dst_addr_hi
			&& strm_key[s].dst_addr_lo == k.dst_addr_lo && strm_key[s].dst_l4 == k.dst_l4;
	endfunction

	function automatic bit ends_rev(int s, key_t k);
		return strm_key[s].dst_addr_hi == k.src_addr_hi && strm_key[s].dst_addr_lo == k.src_addr_lo
			&& strm_key[s].dst_l4 == k.src_l4 && strm_key[s].src_addr_hi == k.dst_addr_hi
			&& strm_key[s].src_addr_lo == k.dst_addr_lo && strm_key[s].src_l4 == k.dst_l4;
	endfunction

	function automatic res_t track_packet(key_t raw);
		key_t k;
		res_t r;
		k = clean_key(raw);
		r = '{stream_index: '0, direction: 1'b0, outcome: OUT_FULL, is_complete: 1'b0};
		for (int s = 0; s < strm_count; s++) begin
			if (!strm_valid[s] || !strm_done[s] || strm_key[s].is_ipv6 != k.is_ipv6)
				continue;
			if (strm_key[s].flow_id == k.flow_id && ends_fwd(s, k)) begin
				r = '{stream_index: s[9:0], direction: 1'b0, outcome: OUT_EST, is_complete: 1'b1};
				return r;
			end
			if (strm_rev_id[s] == k.flow_id && ends_rev(s, k)) begin
				r = '{stream_index: s[9:0], direction: 1'b1, outcome: OUT_EST, is_complete: 1'b1};
				return r;
			end
		end
		for (int s = 0; s < strm_count; s++)
			if (strm_valid[s] && !strm_done[s] && strm_key[s].is_ipv6 == k.is_ipv6
					&& ends_fwd(s, k)) begin
				r = '{stream_index: s[9:0], direction: 1'b0, outcome: OUT_PEND_FWD,
					is_complete: 1'b0};
				return r;
			end
		for (int s = 0; s < strm_count; s++)
			if (strm_valid[s] && !strm_done[s] && strm_key[s].is_ipv6 == k.is_ipv6
					&& ends_rev(s, k)) begin
				strm_done[s] = 1'b1;
				strm_rev_id[s] = k.flow_id;
				r = '{stream_index: s[9:0], direction: 1'b1, outcome: OUT_COMPLETED,
					is_complete: 1'b1};
				return r;
			end
		if (strm_count >= NSLOTS)
			return r;
		strm_key[strm_count] = k;
		strm_valid[strm_count] = 1'b1;
		strm_done[strm_count] = 1'b0;
		strm_rev_id[strm_count] = '0;
		r = '{stream_index: strm_count[9:0], direction: 1'b0, outcome: OUT_CREATED,
			is_complete: 1'b0};
		strm_count++;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch @%0t result %0d: %s got %0d want %0d", $realtime, n_checked, what,
			got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		key_t k;
		res_t want;
		if (!arst_n) begin
			errors <= 0;
			n_checked <= 0;
			n_completed <= 0;
			n_established <= 0;
			n_full <= 0;
			strm_count = 0;
			for (int s = 0; s < NSLOTS; s++) begin
				strm_valid[s] = 1'b0;
				strm_done[s] = 1'b0;
			end
			lookups_due.delete();
		end else begin
			// compare before pushing so a same-edge request is never matched
			if (res.valid && res.ready) begin
				if (lookups_due.size() == 0) begin
					report("unexpected result, outcome", res.outcome, 0);
				end else begin
					want = lookups_due.pop_front();
					if (res.stream_index !== want.stream_index)
						report("stream_index", res.stream_index, want.stream_index);
					if (res.direction !== want.direction)
						report("direction", res.direction, want.direction);
					if (res.outcome !== want.outcome)
						report("outcome", res.outcome, want.outcome);
					if (res.is_complete !== want.is_complete)
						report("is_complete", res.is_complete, want.is_complete);
					case (want.outcome)
						OUT_COMPLETED: n_completed <= n_completed + 1;
						OUT_EST:       n_established <= n_established + 1;
						OUT_FULL:      n_full <= n_full + 1;
						default: ;
					endcase
				end
				n_checked <= n_checked + 1;
			end
			if (pkt.valid && pkt.ready) begin
				k = '{is_ipv6: pkt.is_ipv6, src_addr_hi: pkt.src_addr_hi,
					src_addr_lo: pkt.src_addr_lo, src_l4: pkt.src_l4,
					dst_addr_hi: pkt.dst_addr_hi, dst_addr_lo: pkt.dst_addr_lo,
					dst_l4: pkt.dst_l4, flow_id: pkt.flow_id};
				lookups_due.push_back(track_packet(k));
			end
		end
	end

	assign outstanding = lookups_due.size();
endmodule

FILE: tb/bidirectional_flow_tracker_tb.sv
module bidirectional_flow_tracker_tb;
	import bft_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1830;

	logic clk;
	logic arst_n;
	int   errors, outstanding, n_checked, n_completed, n_established, n_full;
	int   n_sent;
	bit   calm;      // stretches with no idling on either side
	key_t sent_keys [$];

	bft_in_if  pkt ();
	bft_out_if res ();

	bidirectional_flow_tracker dut (.clk(clk), .arst_n(arst_n), .pkt(pkt), .res(res));

	bft_flow_checker chk (.clk(clk), .arst_n(arst_n), .pkt(pkt), .res(res),
		.errors(errors), .outstanding(outstanding), .n_checked(n_checked),
		.n_completed(n_completed), .n_established(n_established), .n_full(n_full));

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("timeout with %0d lookups outstanding", outstanding);
		$display("TB_ERROR");
		$finish;
	end

	function automatic int idle_draw();
		if (calm)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	task automatic send_packet(key_t k);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			pkt.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt.is_ipv6     <= k.is_ipv6;
		pkt.src_addr_hi <= k.src_addr_hi;
		pkt.src_addr_lo <= k.src_addr_lo;
		pkt.src_l4      <= k.src_l4;
		pkt.dst_addr_hi <= k.dst_addr_hi;
		pkt.dst_addr_lo <= k.dst_addr_lo;
		pkt.dst_l4      <= k.dst_l4;
		pkt.flow_id     <= k.flow_id;
		pkt.valid       <= 1'b1;
		do @(posedge clk); while (!pkt.ready);
		sent_keys.push_back(k);
		n_sent++;
	endtask

	function automatic key_t fresh_key();
		key_t k;
		k.is_ipv6     = 1'($urandom_range(0, 1));
		k.src_addr_hi = {$urandom, $urandom};
		k.src_addr_lo = {$urandom, $urandom};
		k.dst_addr_hi = {$urandom, $urandom};
		k.dst_addr_lo = {$urandom, $urandom};
		k.src_l4      = 16'($urandom);
		k.dst_l4      = 16'($urandom);
		k.flow_id     = $urandom;
		return k;
	endfunction

	function automatic key_t swap_ends(key_t k);
		key_t r;
		r = k;
		r.src_addr_hi = k.dst_addr_hi;
		r.src_addr_lo = k.dst_addr_lo;
		r.src_l4      = k.dst_l4;
		r.dst_addr_hi = k.src_addr_hi;
		r.dst_addr_lo = k.src_addr_lo;
		r.dst_l4      = k.src_l4;
		return r;
	endfunction

	// a key built from earlier traffic: repeat, reverse, new id, other family, reverse with an earlier id
	function automatic key_t related_key();
		key_t k;
		int   pick;
		k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
		pick = $urandom_range(0, 99);
		if (pick < 40)
			k = swap_ends(k);
		else if (pick < 50)
			k.flow_id = $urandom;
		else if (pick < 55)
			k.is_ipv6 = ~k.is_ipv6;
		else if (pick < 62) begin
			k = swap_ends(k);
			k.flow_id = sent_keys[$urandom_range(0, sent_keys.size() - 1)].flow_id;
		end
		// IPv4 keys sometimes carry junk in the ignored address bits
		if (!k.is_ipv6 && $urandom_range(0, 1)) begin
			k.src_addr_hi = {$urandom, $urandom};
			k.dst_addr_hi = {$urandom, $urandom};
			k.src_addr_lo[63:32] = $urandom;
			k.dst_addr_lo[63:32] = $urandom;
		end
		return k;
	endfunction

	// result side stall, drawn per result
	initial begin
		int w;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = idle_draw();
			if (w > 0) begin
				res.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!(res.valid && res.ready));
		end
	end

	initial begin
		key_t k, a;
		int   wait_cycles;
		pkt.valid = 1'b0;
		pkt.is_ipv6 = 1'b0;
		pkt.src_addr_hi = '0;
		pkt.src_addr_lo = '0;
		pkt.src_l4 = '0;
		pkt.dst_addr_hi = '0;
		pkt.dst_addr_lo = '0;
		pkt.dst_l4 = '0;
		pkt.flow_id = '0;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every outcome but table full, IPv4 junk bits, same-ends stream
		send_packet('0);
		send_packet('0);
		send_packet('1);
		a = '{is_ipv6: 1'b0, src_addr_hi: '1, src_addr_lo: 64'hFFFF_FFFF_0A00_0001,
			src_l4: 16'hFFFF, dst_addr_hi: 64'h1234, dst_addr_lo: 64'h5555_0000_0A00_0002,
			dst_l4: 16'd0, flow_id: 32'hFFFF_FFFF};
		send_packet(a);
		k = a;
		k.src_addr_hi = '0;
		k.dst_addr_hi = '0;
		k.src_addr_lo[63:32] = '0;
		k.dst_addr_lo[63:32] = '0;
		k.flow_id = 32'd7;
		send_packet(k);
		k = swap_ends(a);
		k.flow_id = 32'h0;
		send_packet(k);
		send_packet(k);
		send_packet(a);
		k.flow_id = 32'h1;
		send_packet(k);
		k = a;
		k.is_ipv6 = 1'b1;
		send_packet(k);
		send_packet(swap_ends(k));
		send_packet(swap_ends('1));
		k = '1;
		k.flow_id = '0;
		send_packet(k);
		k.src_l4 = 16'h0;
		send_packet(k);
		send_packet(swap_ends(k));
		send_packet(swap_ends(k));

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 64 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (i == N_RANDOM / 3) begin
				// hold off until the tracker has answered everything
				pkt.valid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			if ($urandom_range(0, 99) < 55)
				send_packet(fresh_key());
			else
				send_packet(related_key());
		end
		pkt.valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		wait_cycles = 1100;
		repeat (wait_cycles) @(posedge clk);
		$display("%0d packets sent, %0d results checked", n_sent, n_checked);
		$display("completions %0d, established hits %0d, table-full answers %0d",
			n_completed, n_established, n_full);
		if (errors == 0 && n_checked == n_sent)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

FILE: bidirectional_flow_tracker.f
+incdir+src
src/bft_pkg.sv
src/bft_if.sv
src/bft_ram.sv
src/bft_front.sv
src/bft_engine.sv
src/bidirectional_flow_tracker.sv
tb/bft_flow_checker.sv
tb/bidirectional_flow_tracker_tb.sv
